### hdl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants of the bilinear texture sampler
// Fixed-point formats, item opcodes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

	// fixed-point coordinate format
	localparam int FRAC_BITS = 16;

	// item opcodes
	typedef enum logic [0:0] {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	// configuration register indexes
	localparam logic [0:0] REG_TEX_WIDTH  = 1'b0;
	localparam logic [0:0] REG_TEX_HEIGHT = 1'b1;

	// texture dimension register (1..256 meaningful, 9 bits wide)
	typedef logic [8:0] dim_t;
	localparam dim_t DIM_RESET = 9'd256;

	// texel column/row reach W+1 at most
	typedef logic [9:0] col_t;

	// scaled coordinate: 18-bit coord times up to 510, 16 fraction bits
	typedef logic signed [27:0] fix_t;

	// packed texel {red, green, blue}
	typedef logic [23:0] rgb_t;

	// bilinear weight, up to exactly 2^32
	typedef logic [32:0] wt_t;
	typedef logic [16:0] frac1_t;

	// weight times one channel, and the four-term sum
	typedef logic [40:0] prod_t;
	localparam prod_t ROUND_HALF = 41'h0_8000_0000;

	// neighbor validity, one bit per column/row offset
	typedef struct packed {
		logic [1:0] col_ok;
		logic [1:0] row_ok;
	} nbr_ok_t;

	// out-of-bounds color
	localparam logic [7:0] OOB_RED   = 8'hFF;
	localparam logic [7:0] OOB_GREEN = 8'h00;
	localparam logic [7:0] OOB_BLUE  = 8'h00;

endpackage

`default_nettype wire

### hdl/bts_tex_bank.sv
// ----------------------------------------------------------------------------
// bts_tex_bank: one bank of the texture store
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_tex_bank #(
	parameter int AW = 14
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire bts_pkg::rgb_t wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output bts_pkg::rgb_t      rd_data
);

	localparam int DEPTH = 1 << AW;

	bts_pkg::rgb_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, old data on a same-cycle write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hdl/bilinear_texture_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler: RGB texture store with a bilinear sample pipeline
// Input channel (in_valid/in_ready) carries write items, which store one texel,
// and sample items, which return one filtered color on the output channel
// (out_valid/out_ready). Writes return nothing.
// Throughput: one item per cycle while in_ready is high. A sample passes the
// stage 1, 2 and 3 registers and the output register; the texel store is four
// banks split by column and row parity, so its four neighbors are read at once.
// Pipeline stages: scale, bank read + weights, products, sum + round.
// Configuration (cfg_we/cfg_index/cfg_wdata) sets texture width and height;
// write it only while no item is in flight.
// Reset: dimensions go to 256, the pipeline empties, texels are undefined
// until written (no clearing pass).
// Receiver stall: results back up into the pipeline stages; in_ready drops
// only once all three stages and the output register hold items.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_texture_sampler #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_we,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [8:0]         cfg_wdata,
	// input items
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               operation,
	input  wire logic [7:0]         texel_x,
	input  wire logic [7:0]         texel_y,
	input  wire logic [7:0]         texel_red,
	input  wire logic [7:0]         texel_green,
	input  wire logic [7:0]         texel_blue,
	input  wire logic signed [17:0] coord_u,
	input  wire logic signed [17:0] coord_v,
	// result items
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              red,
	output logic [7:0]              green,
	output logic [7:0]              blue,
	output logic                    out_of_bounds
);

	// bank address widths: half the columns and half the rows per bank
	localparam int XAW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) - 1 : 1;
	localparam int YAW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) - 1 : 1;
	localparam int BAW = XAW + YAW;

	// configuration registers
	bts_pkg::dim_t tex_width_q;
	bts_pkg::dim_t tex_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= bts_pkg::DIM_RESET;
			tex_height_q <= bts_pkg::DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bts_pkg::REG_TEX_WIDTH:  tex_width_q  <= cfg_wdata;
				bts_pkg::REG_TEX_HEIGHT: tex_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective dimensions, clamped to 1..MAX
	bts_pkg::dim_t w_eff;
	bts_pkg::dim_t h_eff;

	always_comb begin
		if (tex_width_q == '0) begin
			w_eff = 9'd1;
		end else if (32'(tex_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = 9'(MAX_WIDTH);
		end else begin
			w_eff = tex_width_q;
		end
		if (tex_height_q == '0) begin
			h_eff = 9'd1;
		end else if (32'(tex_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = 9'(MAX_HEIGHT);
		end else begin
			h_eff = tex_height_q;
		end
	end

	// pipeline handshake: each stage moves when the next is free or moving
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic s1_rdy, s2_rdy, s3_rdy, out_rdy;
	logic in_acc, smp_acc, wr_acc;

	assign out_rdy  = !out_valid_q || out_ready;
	assign s3_rdy   = !v_s3 || out_rdy;
	assign s2_rdy   = !v_s2 || s3_rdy;
	assign s1_rdy   = !v_s1 || s2_rdy;
	assign in_ready = s1_rdy;
	assign in_acc   = in_valid && in_ready;
	assign smp_acc  = in_acc && (operation == bts_pkg::OP_SAMPLE);
	assign wr_acc   = in_acc && (operation == bts_pkg::OP_WRITE)
		&& (32'(texel_x) < 32'(MAX_WIDTH)) && (32'(texel_y) < 32'(MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_rdy)  v_s1        <= smp_acc;
			if (s2_rdy)  v_s2        <= v_s1;
			if (s3_rdy)  v_s3        <= v_s2;
			if (out_rdy) out_valid_q <= v_s3;
		end
	end

	// stage 1: scale coordinates into texel space
	bts_pkg::fix_t su_s1, sv_s1;
	bts_pkg::fix_t u_ext, v_ext, wm1_ext, hm1_ext;

	assign u_ext   = bts_pkg::fix_t'(coord_u);
	assign v_ext   = bts_pkg::fix_t'(coord_v);
	assign wm1_ext = bts_pkg::fix_t'({1'b0, w_eff - 9'd1});
	assign hm1_ext = bts_pkg::fix_t'({1'b0, h_eff - 9'd1});

	always_ff @(posedge clk) begin
		if (s1_rdy) begin
			su_s1 <= u_ext * wm1_ext;
			sv_s1 <= v_ext * hm1_ext;
		end
	end

	// stage 1 -> 2: bounds, neighbor addresses, weights
	logic            oob_c;
	bts_pkg::col_t   x0, x1, y0, y1;
	logic [15:0]     dx, dy;
	bts_pkg::frac1_t odx, ody;
	bts_pkg::nbr_ok_t ok_c;

	always_comb begin
		oob_c = su_s1[27] || sv_s1[27]
			|| (su_s1[26:0] > 27'({w_eff, 16'h0000}))
			|| (sv_s1[26:0] > 27'({h_eff, 16'h0000}));
		x0  = su_s1[25:16];
		y0  = sv_s1[25:16];
		x1  = x0 + 10'd1;
		y1  = y0 + 10'd1;
		dx  = su_s1[15:0];
		dy  = sv_s1[15:0];
		odx = 17'h10000 - {1'b0, dx};
		ody = 17'h10000 - {1'b0, dy};
		ok_c.col_ok[0] = x0 < {1'b0, w_eff};
		ok_c.col_ok[1] = x1 < {1'b0, w_eff};
		ok_c.row_ok[0] = y0 < {1'b0, h_eff};
		ok_c.row_ok[1] = y1 < {1'b0, h_eff};
	end

	logic             oob_s2;
	logic             xpar_s2, ypar_s2;
	bts_pkg::nbr_ok_t ok_s2;
	bts_pkg::wt_t     wt_s2 [4];

	// weight k: bit 1 = column offset, bit 0 = row offset
	always_ff @(posedge clk) begin
		if (s2_rdy) begin
			oob_s2   <= oob_c;
			xpar_s2  <= x0[0];
			ypar_s2  <= y0[0];
			ok_s2    <= ok_c;
			wt_s2[0] <= bts_pkg::wt_t'(odx) * bts_pkg::wt_t'(ody);
			wt_s2[1] <= bts_pkg::wt_t'(odx) * bts_pkg::wt_t'({1'b0, dy});
			wt_s2[2] <= bts_pkg::wt_t'({1'b0, dx}) * bts_pkg::wt_t'(ody);
			wt_s2[3] <= bts_pkg::wt_t'({1'b0, dx}) * bts_pkg::wt_t'({1'b0, dy});
		end
	end

	// texture banks, bank index = {row parity, column parity}
	bts_pkg::rgb_t bank_rd_s2 [4];
	logic          bank_we [4];
	logic [BAW-1:0] wr_addr;

	assign wr_addr = {YAW'(texel_y >> 1), XAW'(texel_x >> 1)};

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic PX = 1'(b % 2);
		localparam logic PY = 1'(b / 2);

		bts_pkg::col_t  cx, cy;
		logic [BAW-1:0] rd_addr;

		// neighbor of this parity: either x0 or x0+1
		assign cx      = (x0[0] == PX) ? x0 : x1;
		assign cy      = (y0[0] == PY) ? y0 : y1;
		assign rd_addr = {YAW'(cy >> 1), XAW'(cx >> 1)};
		assign bank_we[b] = wr_acc && (texel_x[0] == PX) && (texel_y[0] == PY);

		bts_tex_bank #(
			.AW(BAW)
		) u_bank (
			.clk     (clk),
			.wr_en   (bank_we[b]),
			.wr_addr (wr_addr),
			.wr_data ({texel_red, texel_green, texel_blue}),
			.rd_en   (s2_rdy),
			.rd_addr (rd_addr),
			.rd_data (bank_rd_s2[b])
		);
	end

	// stage 2 -> 3: route banks to neighbors, black outside, weight products
	bts_pkg::rgb_t  nbr [4];
	bts_pkg::prod_t prod_c [3][4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (ok_s2.col_ok[k / 2] && ok_s2.row_ok[k % 2]) begin
				nbr[k] = bank_rd_s2[{ypar_s2 ^ 1'(k % 2), xpar_s2 ^ 1'(k / 2)}];
			end else begin
				nbr[k] = '0;
			end
			for (int ch = 0; ch < 3; ch++) begin
				prod_c[ch][k] = bts_pkg::prod_t'(wt_s2[k])
					* bts_pkg::prod_t'(nbr[k][23 - 8 * ch -: 8]);
			end
		end
	end

	logic           oob_s3;
	bts_pkg::prod_t prod_s3 [3][4];

	always_ff @(posedge clk) begin
		if (s3_rdy) begin
			oob_s3  <= oob_s2;
			prod_s3 <= prod_c;
		end
	end

	// stage 3 -> output: sum, round half up
	logic [7:0]     chan_c [3];
	bts_pkg::prod_t acc_c;

	always_comb begin
		acc_c = '0;
		for (int ch = 0; ch < 3; ch++) begin
			acc_c = prod_s3[ch][0] + prod_s3[ch][1] + prod_s3[ch][2] + prod_s3[ch][3]
				+ bts_pkg::ROUND_HALF;
			chan_c[ch] = acc_c[39:32];
		end
	end

	logic [7:0] red_q, green_q, blue_q;
	logic       oob_q;

	always_ff @(posedge clk) begin
		if (out_rdy) begin
			red_q   <= oob_s3 ? bts_pkg::OOB_RED   : chan_c[0];
			green_q <= oob_s3 ? bts_pkg::OOB_GREEN : chan_c[1];
			blue_q  <= oob_s3 ? bts_pkg::OOB_BLUE  : chan_c[2];
			oob_q   <= oob_s3;
		end
	end

	assign out_valid     = out_valid_q;
	assign red           = red_q;
	assign green         = green_q;
	assign blue          = blue_q;
	assign out_of_bounds = oob_q;

endmodule

`default_nettype wire

### hdl/bts_checker.sv
// ----------------------------------------------------------------------------
// bts_checker: port-level checks for the bilinear texture sampler
// Watches the item channels and bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue,
	input wire logic       out_of_bounds
);

	// no result is shown once reset has been seen at an edge
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result item shown during reset");

	// input backs up only when the output is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled with output free");

	// out-of-bounds items carry pure red
	a_oob_red: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_of_bounds) |-> (red == 8'hFF && green == 8'h00 && blue == 8'h00))
		else $error("out-of-bounds item not red");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable({red, green, blue, out_of_bounds})))
		else $error("stalled result item changed");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.red           (red),
	.green         (green),
	.blue          (blue),
	.out_of_bounds (out_of_bounds)
);

`default_nettype wire
